>>> rtl/assert_macros.svh
// Assertion macros shared by the controller and datapath of the event queue.
// Needs signals aclk and aresetn in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every cycle outside reset
`define SPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// antecedent in a cycle implies consequent in the next
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/speq_pkg.sv
// Package for the stable priority event queue: sizes, opcodes, status codes
// and the command/status structs between controller and datapath. No dependencies.
package speq_pkg;

    localparam int DEPTH     = 16;
    localparam int PRIO_BITS = 8;
    localparam int TAG_BITS  = 16;
    localparam int CNT_W     = $clog2(DEPTH + 1);

    localparam int OP_W   = 2;
    localparam int TAG_W  = 16;
    localparam int PRIO_W = 8;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    localparam logic [OP_W-1:0] OP_POST  = 2'd0;
    localparam logic [OP_W-1:0] OP_GET   = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic              load;
        logic              insert;
        logic              remove;
        logic              clear;
        logic [STAT_W-1:0] status;
    } speq_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } speq_stat_t;

endpackage

>>> rtl/speq_ctrl.sv
// Controller of the event queue: handshake state machine and opcode decode.
// Depends on speq_pkg and assert_macros.svh.
module speq_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [speq_pkg::OP_W-1:0]  s_opcode,
    output logic                       m_valid,
    input  logic                       m_ready,
    input  speq_pkg::speq_stat_t       dp_stat,
    output speq_pkg::speq_cmd_t        dp_cmd
);
    import speq_pkg::*;
    `include "assert_macros.svh"

    localparam logic S_IDLE = 1'b0;
    localparam logic S_HOLD = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    assign m_valid = (state_reg == S_HOLD);
    assign s_ready = (state_reg == S_IDLE) || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        if (accept) begin
            state_next = S_HOLD;
        end else if (m_ready) begin
            state_next = S_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        dp_cmd        = '0;
        dp_cmd.load   = accept;
        dp_cmd.status = ST_OK;
        case (s_opcode)
            OP_POST: begin
                if (dp_stat.full) begin
                    dp_cmd.status = ST_FULL;
                end else begin
                    dp_cmd.insert = accept;
                end
            end
            OP_GET: begin
                if (dp_stat.empty) begin
                    dp_cmd.status = ST_EMPTY;
                end else begin
                    dp_cmd.remove = accept;
                end
            end
            OP_FLUSH: begin
                dp_cmd.clear = accept;
            end
            default: begin
            end
        endcase
    end

    `SPQ_ASSERT(a_cmd_needs_load, (!(dp_cmd.insert || dp_cmd.remove || dp_cmd.clear) || dp_cmd.load), "queue command without transfer")
    `SPQ_ASSERT_NEXT(a_load_shows_result, dp_cmd.load, m_valid, "result missing after transfer")

endmodule

>>> rtl/speq_dpath.sv
// Datapath of the event queue: sorted shift-register cells, entry count and
// result register. Depends on speq_pkg and assert_macros.svh.
module speq_dpath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [speq_pkg::TAG_W-1:0]   s_event_tag,
    input  logic [speq_pkg::PRIO_W-1:0]  s_priority_req,
    input  speq_pkg::speq_cmd_t          dp_cmd,
    output speq_pkg::speq_stat_t         dp_stat,
    output logic [speq_pkg::STAT_W-1:0]  m_status,
    output logic [speq_pkg::TAG_W-1:0]   m_out_tag,
    output logic [speq_pkg::PRIO_W-1:0]  m_out_priority,
    output logic [speq_pkg::OCC_W-1:0]   m_occupancy
);
    import speq_pkg::*;
    `include "assert_macros.svh"

    logic [TAG_BITS-1:0]  tag_reg  [DEPTH];
    logic [PRIO_BITS-1:0] prio_reg [DEPTH];
    logic [TAG_BITS-1:0]  tag_next [DEPTH];
    logic [PRIO_BITS-1:0] prio_next[DEPTH];
    logic [DEPTH-1:0]     after_new;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [TAG_BITS-1:0]  new_tag;
    logic [PRIO_BITS-1:0] new_prio;

    logic [STAT_W-1:0]    status_reg;
    logic [TAG_W-1:0]     out_tag_reg;
    logic [PRIO_W-1:0]    out_prio_reg;
    logic [OCC_W-1:0]     occ_reg;

    assign new_tag  = s_event_tag[TAG_BITS-1:0];
    assign new_prio = s_priority_req[PRIO_BITS-1:0];

    assign dp_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign dp_stat.empty = (count_reg == '0);

    // free cells count as less urgent, so after_new is 0..0 1..1
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic                 first_after;
        logic [TAG_BITS-1:0]  ins_tag;
        logic [PRIO_BITS-1:0] ins_prio;
        logic [TAG_BITS-1:0]  rem_tag;
        logic [PRIO_BITS-1:0] rem_prio;

        assign after_new[gi] = (CNT_W'(gi) >= count_reg) || (new_prio < prio_reg[gi]);

        if (gi == 0) begin : g_head
            assign first_after = after_new[gi];
            assign ins_tag     = after_new[gi] ? new_tag : tag_reg[gi];
            assign ins_prio    = after_new[gi] ? new_prio : prio_reg[gi];
        end else begin : g_body
            assign first_after = after_new[gi] && !after_new[gi-1];
            assign ins_tag     = !after_new[gi] ? tag_reg[gi]
                               : (first_after ? new_tag : tag_reg[gi-1]);
            assign ins_prio    = !after_new[gi] ? prio_reg[gi]
                               : (first_after ? new_prio : prio_reg[gi-1]);
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign rem_tag  = tag_reg[gi];
            assign rem_prio = prio_reg[gi];
        end else begin : g_mid
            assign rem_tag  = tag_reg[gi+1];
            assign rem_prio = prio_reg[gi+1];
        end

        assign tag_next[gi]  = dp_cmd.insert ? ins_tag
                             : (dp_cmd.remove ? rem_tag : tag_reg[gi]);
        assign prio_next[gi] = dp_cmd.insert ? ins_prio
                             : (dp_cmd.remove ? rem_prio : prio_reg[gi]);
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            tag_reg[i]  <= tag_next[i];
            prio_reg[i] <= prio_next[i];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (dp_cmd.clear) begin
            count_next = '0;
        end else if (dp_cmd.insert) begin
            count_next = count_reg + CNT_W'(1);
        end else if (dp_cmd.remove) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.load) begin
            status_reg   <= dp_cmd.status;
            out_tag_reg  <= dp_cmd.remove ? TAG_W'(tag_reg[0]) : '0;
            out_prio_reg <= dp_cmd.remove ? PRIO_W'(prio_reg[0]) : '0;
            occ_reg      <= OCC_W'(count_next);
        end
    end

    assign m_status       = status_reg;
    assign m_out_tag      = out_tag_reg;
    assign m_out_priority = out_prio_reg;
    assign m_occupancy    = occ_reg;

    `SPQ_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "entry count above depth")
    `SPQ_ASSERT(a_no_post_full, !(dp_cmd.insert && dp_stat.full), "insert into full queue")
    `SPQ_ASSERT_NEXT(a_clear_empties, dp_cmd.clear, count_reg == '0, "flush left entries")

endmodule

>>> rtl/stable_priority_event_queue.sv
// Top level of the stable priority event queue: controller plus cell datapath.
// Depends on speq_pkg, speq_ctrl and speq_dpath.
//
//   channel  direction  ports
//   s_       in         s_valid, s_ready, s_opcode, s_event_tag, s_priority_req
//   m_       out        m_valid, m_ready, m_status, m_out_tag, m_out_priority,
//                       m_occupancy
//
// Every operation completes in the cycle it is accepted; all cells compare in
// parallel, so one item per cycle unless stalled. The result appears in the
// cycle after transfer. A new item is taken while the result register is
// empty or being read. Reset (aresetn low, synchronous) empties the queue and
// the result register; a stalled result holds s_ready low until m_ready rises.
module stable_priority_event_queue (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [speq_pkg::OP_W-1:0]    s_opcode,
    input  logic [speq_pkg::TAG_W-1:0]   s_event_tag,
    input  logic [speq_pkg::PRIO_W-1:0]  s_priority_req,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [speq_pkg::STAT_W-1:0]  m_status,
    output logic [speq_pkg::TAG_W-1:0]   m_out_tag,
    output logic [speq_pkg::PRIO_W-1:0]  m_out_priority,
    output logic [speq_pkg::OCC_W-1:0]   m_occupancy
);
    import speq_pkg::*;

    speq_cmd_t  dp_cmd;
    speq_stat_t dp_stat;

    speq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .dp_stat  (dp_stat),
        .dp_cmd   (dp_cmd)
    );

    speq_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_event_tag    (s_event_tag),
        .s_priority_req (s_priority_req),
        .dp_cmd         (dp_cmd),
        .dp_stat        (dp_stat),
        .m_status       (m_status),
        .m_out_tag      (m_out_tag),
        .m_out_priority (m_out_priority),
        .m_occupancy    (m_occupancy)
    );

endmodule
